/* sv/crlf_pkg.sv */
package crlf_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 8;
    localparam int LEN_W         = 6;
    localparam int MIN_CMD_BYTES = 2;

    localparam logic [DATA_W-1:0] CR_BYTE = 8'h0D;
    localparam logic [DATA_W-1:0] LF_BYTE = 8'h0A;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_FETCH = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        KIND_STATUS = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_NONE   = 2'd2
    } kind_t;

    typedef struct packed
    {
        func_t             func;
        logic [DATA_W-1:0] data;
        logic              chunk_start;
        logic [LEN_W-1:0]  chunk_length;
    } cmd_t;

    typedef struct packed
    {
        kind_t             kind;
        logic [DATA_W-1:0] byte_out;
        logic              last;
        logic              accepted;
        logic [LEN_W-1:0]  command_length;
    } rsp_t;

endpackage

/* sv/crlf_command_ring_buffer.sv */
// Channel   Ports              Handshake
// ------    -----------------  ----------------------------------------------
// command   cmd                start high and busy low at a rising edge
// result    rsp                done high for one cycle, no back pressure
//
// A byte write does not hold the block; busy stays low. A fetch with fewer than
// two bytes held does not hold it either; else busy stays high while the held
// bytes are scanned for a CR LF terminator and the command bytes are sent (all
// held bytes are scanned when none is found); each result is registered.
// Scan and emit share one store read port and one ring adder, a byte a cycle.
// Reset clears the state, pointers, reject flag and result registers, not the store. The receiver cannot stall.
module crlf_command_ring_buffer
    import crlf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int PTR_W = $clog2(DEPTH)
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int CNT_W = PTR_W;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W + 1 : LEN_W + 1;
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] MIN_LEN  = CNT_W'(MIN_CMD_BYTES);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t            state_reg;
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  wp_reg;
    logic              rej_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  len_reg;
    logic              prev_cr_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic              accept;
    logic [PTR_W:0]    held_full;
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  free_cnt;
    logic              rej_next;
    logic              stored;
    logic              we;
    logic [PTR_W-1:0]  wp_next;
    logic [CNT_W-1:0]  idx_inc;
    logic              match;
    logic              end_scan;
    logic              emit_last;
    logic              issue_en;
    logic [CNT_W-1:0]  ring_off;
    logic [PTR_W:0]    ring_sum;
    logic [PTR_W-1:0]  ring_addr;
    logic [DATA_W-1:0] rdata;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            held_full = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            held_full = {1'b0, wp_reg} + DEPTH_X - {1'b0, rp_reg};
        end
    end

    assign held     = held_full[CNT_W-1:0];
    assign free_cnt = CAPACITY - held;

    // Reject decision is taken only at the first byte of a chunk.
    assign rej_next = cmd.chunk_start ? (CMP_W'(free_cnt) < CMP_W'(cmd.chunk_length)) : rej_reg;
    assign stored   = !rej_next && (free_cnt != '0);
    assign we       = accept && (cmd.func == FUNC_WRITE) && stored;
    assign wp_next  = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign match     = prev_cr_reg && (rdata == LF_BYTE);
    assign end_scan  = (idx_inc == held);
    assign emit_last = (idx_inc == len_reg);

    // Shared ring adder: read addresses and the new read pointer.
    always_comb
    begin
        issue_en = 1'b0;
        ring_off = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                issue_en = accept && (cmd.func == FUNC_FETCH) && (held >= MIN_LEN);
            end
            S_SCAN:
            begin
                priority if (match)
                begin
                    issue_en = 1'b1;
                end
                else if (!end_scan)
                begin
                    issue_en = 1'b1;
                    ring_off = idx_inc;
                end
                else
                begin
                    ring_off = CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (emit_last)
                begin
                    ring_off = len_reg;
                end
                else
                begin
                    issue_en = 1'b1;
                    ring_off = idx_inc;
                end
            end
            default:
            begin
                issue_en = 1'b0;
            end
        endcase
    end

    assign ring_sum  = {1'b0, rp_reg} + {1'b0, ring_off};
    assign ring_addr = (ring_sum >= DEPTH_X) ? PTR_W'(ring_sum - DEPTH_X) : ring_sum[PTR_W-1:0];

    crlf_byte_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (cmd.data),
        .re    (issue_en),
        .raddr (ring_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rp_reg      <= '0;
            wp_reg      <= '0;
            rej_reg     <= 1'b0;
            idx_reg     <= '0;
            len_reg     <= '0;
            prev_cr_reg <= 1'b0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.func == FUNC_WRITE)
                        begin
                            rej_reg  <= rej_next;
                            if (stored)
                            begin
                                wp_reg <= wp_next;
                            end
                            done_reg <= 1'b1;
                            rsp_reg  <= '{kind: KIND_STATUS, byte_out: '0, last: 1'b1,
                                          accepted: stored, command_length: '0};
                        end
                        else if (held < MIN_LEN)
                        begin
                            done_reg <= 1'b1;
                            rsp_reg  <= '{kind: KIND_NONE, byte_out: '0, last: 1'b1,
                                          accepted: 1'b0, command_length: '0};
                        end
                        else
                        begin
                            idx_reg     <= '0;
                            prev_cr_reg <= 1'b0;
                            state_reg   <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    priority if (match)
                    begin
                        len_reg   <= idx_inc;
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (end_scan)
                    begin
                        // full ring with no terminator: drop the oldest byte
                        if (free_cnt == '0)
                        begin
                            rp_reg <= ring_addr;
                        end
                        done_reg  <= 1'b1;
                        rsp_reg   <= '{kind: KIND_NONE, byte_out: '0, last: 1'b1,
                                       accepted: 1'b0, command_length: '0};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg     <= idx_inc;
                        prev_cr_reg <= (rdata == CR_BYTE);
                    end
                end
                S_EMIT:
                begin
                    done_reg <= 1'b1;
                    rsp_reg  <= '{kind: KIND_BYTE, byte_out: rdata, last: emit_last,
                                  accepted: 1'b0, command_length: LEN_W'(len_reg)};
                    if (emit_last)
                    begin
                        rp_reg    <= ring_addr;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.kind != KIND_BYTE) |-> rsp_reg.last)
        else $error("status or none result without last");

    a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (len_reg >= MIN_LEN) && (len_reg <= held))
        else $error("command length out of range during emit");

    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.func == FUNC_FETCH) && (held >= MIN_LEN) |=> busy && !done_reg)
        else $error("fetch with held bytes did not start a scan");

    a_last_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.kind == KIND_BYTE) && rsp_reg.last |-> !busy)
        else $error("sequencer busy after last command byte");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg < PTR_W'(DEPTH - 1) || rp_reg == PTR_W'(DEPTH - 1))
        && (wp_reg < PTR_W'(DEPTH - 1) || wp_reg == PTR_W'(DEPTH - 1)))
        else $error("ring pointer beyond depth");

endmodule

/* sv/crlf_byte_ram.sv */
module crlf_byte_ram
    import crlf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
